[rtl/core/sddc_pkg.sv]
`default_nettype none

package sddc_pkg;

   // pipeline depth, one valid bit per stage
   localparam int NUM_STAGES = 5;

   // payload widths
   localparam int SERIAL_W   = 23;
   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_IN_W  = 14;
   localparam int YEAR_OUT_W = 12;

   // mode codes
   localparam logic MODE_DECODE = 1'b0;
   localparam logic MODE_ENCODE = 1'b1;

   // calendar constants
   localparam int SER_MIN         = 4;
   localparam int SER_MAX         = 109211;
   localparam int SER_1900_END    = 36527;
   localparam int REBASE_EARLY    = 4;
   localparam int REBASE_LATE     = 3;
   localparam int CYCLE_DAYS      = 1461;
   localparam int CYCLE_LAST      = 1460;
   localparam int BASE_YEAR       = 1801;
   localparam int YEAR_DAYS       = 365;
   localparam int LAST_CYCLE_YEAR = 3;
   localparam int NO_LEAP_CENTURY = 1900;
   localparam int MONTHS          = 12;
   localparam int FEB             = 2;
   localparam int CENT_YEARS      = 100;
   localparam int CENT_LAST       = 99;
   localparam int YEAR_LIMIT      = 9999;
   localparam int EPOCH_OFFSET    = 657433;

   // reciprocal constants: q = (x * RECIP) >> SHIFT is exact over the used span
   localparam int CYCLE_RECIP   = 183735;
   localparam int CYCLE_RECIP_W = 18;
   localparam int CYCLE_SHIFT   = 28;
   localparam int CENT_RECIP    = 10486;
   localparam int CENT_RECIP_W  = 14;
   localparam int CENT_SHIFT    = 20;

   // internal widths
   localparam int DOFF_W  = 17;  // rebased serial, up to 109208
   localparam int CYC_W   = 7;   // four-year cycle count, up to 74
   localparam int REM_W   = 11;  // day inside a cycle, up to 1460
   localparam int DOY_W   = 9;   // day of year, up to 365
   localparam int BASE_W  = 10;  // days before month plus day, up to 365
   localparam int CENT_W  = 7;   // centuries and remainders below 100
   localparam int YDAYS_W = 22;  // whole-year day count, up to 3651769

   // per-stage load enables from the pipeline control
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

   // non-leap days before the first of a month
   function automatic logic [DOY_W-1:0] month_days_before(input logic [MONTH_W-1:0] month);
      logic [DOY_W-1:0] days;
      case (month)
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

[rtl/core/sddc_if.sv]
`default_nettype none

// request channel
interface sddc_req_if;
   import sddc_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic signed [SERIAL_W-1:0]  serial_in;
   logic [DAY_W-1:0]            in_day;
   logic [MONTH_W-1:0]          in_month;
   logic [YEAR_IN_W-1:0]        in_year;

   modport source (output valid, mode, serial_in, in_day, in_month, in_year, input ready);
   modport sink   (input valid, mode, serial_in, in_day, in_month, in_year, output ready);
endinterface

// response channel
interface sddc_rsp_if;
   import sddc_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [SERIAL_W-1:0]  serial_out;
   logic [DAY_W-1:0]            out_day;
   logic [MONTH_W-1:0]          out_month;
   logic [YEAR_OUT_W-1:0]       out_year;
   logic                        valid_res;

   modport source (output valid, serial_out, out_day, out_month, out_year, valid_res,
                   input ready);
   modport sink   (input valid, serial_out, out_day, out_month, out_year, valid_res,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/serial_day_date_converter_core.sv]
// throughput: one beat per cycle, five beats in flight; stalls hold each stage in place
// ready is an enable chain back from the response side through the five stage registers
// reset (synchronous, active high) empties all stages; payload registers are not reset
`default_nettype none

module serial_day_date_converter_core (
   input  logic         clock,
   input  logic         reset,
   sddc_req_if.sink     req_chan,
   sddc_rsp_if.source   rsp_chan
);
   import sddc_pkg::*;

   pipe_ctl_type ctl;
   logic         dec_ok;
   logic         enc_ok;

   // stage valid bits and load enables
   sddc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .ctl       (ctl)
   );

   // serial to date lane
   sddc_decode u_decode (
      .clock     (clock),
      .ctl       (ctl),
      .mode      (req_chan.mode),
      .serial_in (req_chan.serial_in),
      .out_day   (rsp_chan.out_day),
      .out_month (rsp_chan.out_month),
      .out_year  (rsp_chan.out_year),
      .ok        (dec_ok)
   );

   // date to serial lane
   sddc_encode u_encode (
      .clock      (clock),
      .ctl        (ctl),
      .mode       (req_chan.mode),
      .in_day     (req_chan.in_day),
      .in_month   (req_chan.in_month),
      .in_year    (req_chan.in_year),
      .serial_out (rsp_chan.serial_out),
      .ok         (enc_ok)
   );

   // only the lane that matches the mode can report success
   assign rsp_chan.valid_res = dec_ok | enc_ok;

endmodule

`default_nettype wire

[rtl/core/sddc_pipe_ctrl.sv]
`default_nettype none

module sddc_pipe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sddc_pkg::pipe_ctl_type ctl
);
   import sddc_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   // a stage loads when it is empty or its successor loads
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   // valid bits follow the data
   always_comb begin
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load  = load;
   assign in_ready  = load[0];
   assign out_valid = valid_ff[NUM_STAGES-1];

   // full pipe with a stalled output takes no new beat
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && !out_ready) |-> !in_ready)
      else $error("beat accepted into a full stalled pipeline");

   // an accepted beat lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> valid_ff[0])
      else $error("accepted beat missing from first stage");

   // a held first stage keeps its beat
   a_hold_first: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[0] && !load[0]) |=> valid_ff[0])
      else $error("stalled beat lost in first stage");

   // occupancy grows by at most one beat per cycle
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(valid_ff) <= $past($countones(valid_ff)) + 1))
      else $error("pipeline occupancy jumped");

endmodule

`default_nettype wire

[rtl/core/sddc_decode.sv]
`default_nettype none

module sddc_decode (
   input  logic                                 clock,
   input  sddc_pkg::pipe_ctl_type               ctl,
   input  logic                                 mode,
   input  logic signed [sddc_pkg::SERIAL_W-1:0] serial_in,
   output logic [sddc_pkg::DAY_W-1:0]           out_day,
   output logic [sddc_pkg::MONTH_W-1:0]         out_month,
   output logic [sddc_pkg::YEAR_OUT_W-1:0]      out_year,
   output logic                                 ok
);
   import sddc_pkg::*;

   localparam int PROD_W = DOFF_W + CYCLE_RECIP_W;

   logic                  ok1_in, ok1_ff;
   logic [DOFF_W-1:0]     doff1_in, doff1_ff;

   logic [PROD_W-1:0]     cyc_prod;
   logic                  ok2_ff;
   logic [DOFF_W-1:0]     doff2_ff;
   logic [CYC_W-1:0]      cyc2_in, cyc2_ff;

   logic [DOFF_W-1:0]     cyc_span;
   logic                  ok3_ff;
   logic [REM_W-1:0]      rem3_in, rem3_ff;
   logic [YEAR_OUT_W-1:0] year3_in, year3_ff;

   logic [1:0]            year_off;
   logic [REM_W-1:0]      year_start;
   logic                  ok4_ff;
   logic [DOY_W-1:0]      doy4_in, doy4_ff;
   logic [YEAR_OUT_W-1:0] year4_in, year4_ff;
   logic                  leap4_in, leap4_ff;

   logic [MONTH_W-1:0]    month5_in, month5_ff;
   logic [DAY_W-1:0]      day5_in, day5_ff;
   logic [YEAR_OUT_W-1:0] year5_in, year5_ff;
   logic                  ok5_ff;

   // stage 1: span check and rebase
   always_comb begin
      ok1_in   = (mode == MODE_DECODE) && (serial_in >= SER_MIN) && (serial_in <= SER_MAX);
      doff1_in = DOFF_W'(serial_in) - ((serial_in > SER_1900_END) ?
                 DOFF_W'(REBASE_LATE) : DOFF_W'(REBASE_EARLY));
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         ok1_ff   <= ok1_in;
         doff1_ff <= doff1_in;
      end
   end

   // stage 2: four-year cycle count by reciprocal multiply
   assign cyc_prod = PROD_W'(doff1_ff) * PROD_W'(CYCLE_RECIP);
   assign cyc2_in  = cyc_prod[CYCLE_SHIFT +: CYC_W];

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         ok2_ff   <= ok1_ff;
         doff2_ff <= doff1_ff;
         cyc2_ff  <= cyc2_in;
      end
   end

   // stage 3: day inside the cycle and first year of the cycle
   always_comb begin
      cyc_span = DOFF_W'(cyc2_ff) * DOFF_W'(CYCLE_DAYS);
      rem3_in  = REM_W'(doff2_ff - cyc_span);
      year3_in = YEAR_OUT_W'(BASE_YEAR) + YEAR_OUT_W'({cyc2_ff, 2'b00});
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         ok3_ff   <= ok2_ff;
         rem3_ff  <= rem3_in;
         year3_ff <= year3_in;
      end
   end

   // stage 4: year inside the cycle, day of year, leap flag
   always_comb begin
      if (rem3_ff >= REM_W'(3 * YEAR_DAYS)) begin
         year_off = 2'd3;
      end else if (rem3_ff >= REM_W'(2 * YEAR_DAYS)) begin
         year_off = 2'd2;
      end else if (rem3_ff >= REM_W'(YEAR_DAYS)) begin
         year_off = 2'd1;
      end else begin
         year_off = 2'd0;
      end
      year_start = REM_W'(year_off) * REM_W'(YEAR_DAYS);
      // last day of a cycle stays in the fourth year
      if (rem3_ff == REM_W'(CYCLE_LAST)) begin
         year_off = 2'(LAST_CYCLE_YEAR);
         doy4_in  = DOY_W'(YEAR_DAYS);
      end else begin
         doy4_in  = DOY_W'(rem3_ff - year_start);
      end
      year4_in = year3_ff + YEAR_OUT_W'(year_off);
      // decoded years lie in 1801..2099, so 1900 is the only century to skip
      leap4_in = (year4_in[1:0] == 2'b00) && (year4_in != YEAR_OUT_W'(NO_LEAP_CENTURY));
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         ok4_ff   <= ok3_ff;
         doy4_ff  <= doy4_in;
         year4_ff <= year4_in;
         leap4_ff <= leap4_in;
      end
   end

   // stage 5: month walk as parallel compares against month starts
   always_comb begin
      logic [DOY_W-1:0] bound;
      logic [DOY_W-1:0] start;
      logic [DOY_W-1:0] year_len;
      logic [MONTH_W-1:0] month;
      month    = MONTH_W'(1);
      start    = '0;
      year_len = DOY_W'(YEAR_DAYS) + DOY_W'(leap4_ff);
      for (int m = 2; m <= MONTHS; m++) begin
         bound = month_days_before(MONTH_W'(m)) + DOY_W'(leap4_ff && (m > FEB));
         if (doy4_ff >= bound) begin
            month = MONTH_W'(m);
            start = bound;
         end
      end
      // day past the end of the year finds no month
      if (doy4_ff >= year_len) begin
         month = '0;
         start = year_len;
      end
      if (ok4_ff) begin
         month5_in = month;
         day5_in   = DAY_W'(doy4_ff - start + DOY_W'(1));
         year5_in  = year4_ff;
      end else begin
         month5_in = '0;
         day5_in   = '0;
         year5_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         ok5_ff    <= ok4_ff;
         month5_ff <= month5_in;
         day5_ff   <= day5_in;
         year5_ff  <= year5_in;
      end
   end

   assign out_day   = day5_ff;
   assign out_month = month5_ff;
   assign out_year  = year5_ff;
   assign ok        = ok5_ff;

endmodule

`default_nettype wire

[rtl/core/sddc_encode.sv]
`default_nettype none

module sddc_encode (
   input  logic                                 clock,
   input  sddc_pkg::pipe_ctl_type               ctl,
   input  logic                                 mode,
   input  logic [sddc_pkg::DAY_W-1:0]           in_day,
   input  logic [sddc_pkg::MONTH_W-1:0]         in_month,
   input  logic [sddc_pkg::YEAR_IN_W-1:0]       in_year,
   output logic signed [sddc_pkg::SERIAL_W-1:0] serial_out,
   output logic                                 ok
);
   import sddc_pkg::*;

   localparam int CPROD_W = YEAR_IN_W + CENT_RECIP_W;

   logic                  ok1_in, ok1_ff;
   logic [YEAR_IN_W-1:0]  yb1_in, yb1_ff;
   logic [BASE_W-1:0]     base1_in, base1_ff;
   logic                  late1_in, late1_ff;

   logic [CPROD_W-1:0]    cent_prod;
   logic                  ok2_ff;
   logic [YEAR_IN_W-1:0]  yb2_ff;
   logic [CENT_W-1:0]     cent2_in, cent2_ff;
   logic [YDAYS_W-1:0]    ydays2_in, ydays2_ff;
   logic [BASE_W-1:0]     base2_ff;
   logic                  late2_ff;

   logic [YEAR_IN_W-1:0]  cent_span;
   logic                  ok3_ff;
   logic [CENT_W-1:0]     rem3_in, rem3_ff;
   logic [YDAYS_W-1:0]    part3_in, part3_ff;
   logic [1:0]            yb_lo3_ff;
   logic [1:0]            cent_lo3_ff;
   logic [BASE_W-1:0]     base3_ff;
   logic                  late3_ff;

   logic                  leap4;
   logic                  ok4_ff;
   logic [SERIAL_W-1:0]   sum4_in, sum4_ff;

   logic [SERIAL_W-1:0]   serial5_in, serial5_ff;
   logic                  ok5_ff;

   // stage 1: field checks, year before, days into the year
   always_comb begin
      ok1_in   = (mode == MODE_ENCODE) && (in_day != '0) && (in_month != '0) &&
                 (in_year != '0) && (in_month <= MONTH_W'(MONTHS)) &&
                 (in_year <= YEAR_IN_W'(YEAR_LIMIT));
      yb1_in   = in_year - YEAR_IN_W'(1);
      base1_in = BASE_W'(month_days_before(in_month)) + BASE_W'(in_day);
      late1_in = in_month > MONTH_W'(FEB);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         ok1_ff   <= ok1_in;
         yb1_ff   <= yb1_in;
         base1_ff <= base1_in;
         late1_ff <= late1_in;
      end
   end

   // stage 2: centuries by reciprocal multiply, whole-year days
   assign cent_prod = CPROD_W'(yb1_ff) * CPROD_W'(CENT_RECIP);
   assign cent2_in  = cent_prod[CENT_SHIFT +: CENT_W];
   assign ydays2_in = YDAYS_W'(yb1_ff) * YDAYS_W'(YEAR_DAYS);

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         ok2_ff    <= ok1_ff;
         yb2_ff    <= yb1_ff;
         cent2_ff  <= cent2_in;
         ydays2_ff <= ydays2_in;
         base2_ff  <= base1_ff;
         late2_ff  <= late1_ff;
      end
   end

   // stage 3: year within century, Gregorian day count of the years before
   always_comb begin
      cent_span = YEAR_IN_W'(cent2_ff) * YEAR_IN_W'(CENT_YEARS);
      rem3_in   = CENT_W'(yb2_ff - cent_span);
      part3_in  = ydays2_ff + YDAYS_W'(yb2_ff >> 2) - YDAYS_W'(cent2_ff) +
                  YDAYS_W'(cent2_ff >> 2);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         ok3_ff      <= ok2_ff;
         rem3_ff     <= rem3_in;
         part3_ff    <= part3_in;
         yb_lo3_ff   <= yb2_ff[1:0];
         cent_lo3_ff <= cent2_ff[1:0];
         base3_ff    <= base2_ff;
         late3_ff    <= late2_ff;
      end
   end

   // stage 4: leap test on the year itself, read off the year before it
   always_comb begin
      leap4   = (yb_lo3_ff == 2'b11) &&
                ((rem3_ff != CENT_W'(CENT_LAST)) || (cent_lo3_ff == 2'b11));
      sum4_in = SERIAL_W'(part3_ff) + SERIAL_W'(base3_ff) + SERIAL_W'(leap4 && late3_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         ok4_ff  <= ok3_ff;
         sum4_ff <= sum4_in;
      end
   end

   // stage 5: move to the serial epoch
   assign serial5_in = ok4_ff ? (sum4_ff - SERIAL_W'(EPOCH_OFFSET)) : '0;

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         ok5_ff     <= ok4_ff;
         serial5_ff <= serial5_in;
      end
   end

   assign serial_out = serial5_ff;
   assign ok         = ok5_ff;

endmodule

`default_nettype wire
